FILE: rtl/hkit_pkg.sv
// ----------------------------------------------------------------------------
// hkit_pkg
// Shared types and constants for the hashed key index table.
// ----------------------------------------------------------------------------
package hkit_pkg;

  localparam int ENTRIES_DEF   = 256;
  localparam int SLOT_BITS_DEF = 9;

  localparam int KEY_W     = 256;
  localparam int LIMB_W    = 64;
  localparam int CFG_W     = 4;
  localparam int OP_W      = 2;
  localparam int RIDX_W    = 8;
  localparam int STATUS_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET     = 4'd9;
  localparam logic [4:0]       MIN_SLOT_BITS = 5'd3;

  // splitmix64-style mixer constants
  localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_M1 = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_M2 = 64'h94d0_49bb_1331_11eb;
  localparam int SH_PRE  = 30;
  localparam int SH_MID  = 27;
  localparam int SH_POST = 31;
  localparam int SH_HL   = 6;
  localparam int SH_HR   = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STORE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INDEX_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [LIMB_W-1:0] key_limb0;
    logic [LIMB_W-1:0] key_limb1;
    logic [LIMB_W-1:0] key_limb2;
    logic [LIMB_W-1:0] key_limb3;
  } cmd_t;

  typedef struct packed {
    logic                found;
    logic [RIDX_W-1:0]   result_index;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

FILE: rtl/hkit_ram.sv
// ----------------------------------------------------------------------------
// hkit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hkit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hkit_hash.sv
// ----------------------------------------------------------------------------
// hkit_hash
// Multi-cycle key hash: four rounds of a splitmix64 finalizer on one shared
// 32x32 multiplier, three partial products per 64-bit multiply.
// ----------------------------------------------------------------------------
module hkit_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hkit_pkg::cmd_t      key,
  output logic                done,
  output logic [63:0]         hash
);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_PRE  = 4'b0010,
    H_MUL  = 4'b0100,
    H_POST = 4'b1000
  } hstate_t;

  hstate_t     state;
  logic [63:0] h;
  logic [63:0] v;
  logic [63:0] acc;
  logic [1:0]  limb;
  logic [1:0]  phase;
  logic        second;

  logic [63:0] limb_sel;
  logic [63:0] mix_in;
  logic [63:0] m;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [63:0] prod;
  logic [63:0] acc_next;

  always_comb begin
    unique case (limb)
      2'd0:    limb_sel = key.key_limb0;
      2'd1:    limb_sel = key.key_limb1;
      2'd2:    limb_sel = key.key_limb2;
      default: limb_sel = key.key_limb3;
    endcase
    mix_in = limb_sel + hkit_pkg::GOLDEN + (h << hkit_pkg::SH_HL) + (h >> hkit_pkg::SH_HR);
    m      = second ? hkit_pkg::MIX_M2 : hkit_pkg::MIX_M1;
    // low*low, high*low, low*high; upper cross term drops out of 64 bits
    opa    = (phase == 2'd1) ? v[63:32] : v[31:0];
    opb    = (phase == 2'd2) ? m[63:32] : m[31:0];
    prod   = 64'(opa) * 64'(opb);
    acc_next = (phase == 2'd0) ? prod : acc + {prod[31:0], 32'd0};
  end

  assign hash = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (start) begin
            h     <= hkit_pkg::GOLDEN;
            limb  <= 2'd0;
            state <= H_PRE;
          end
        end
        H_PRE: begin
          v      <= mix_in ^ (mix_in >> hkit_pkg::SH_PRE);
          phase  <= 2'd0;
          second <= 1'b0;
          state  <= H_MUL;
        end
        H_MUL: begin
          acc   <= acc_next;
          phase <= phase + 2'd1;
          if (phase == 2'd2) begin
            state <= H_POST;
          end
        end
        H_POST: begin
          if (!second) begin
            v      <= acc ^ (acc >> hkit_pkg::SH_MID);
            second <= 1'b1;
            phase  <= 2'd0;
            state  <= H_MUL;
          end else begin
            h <= h ^ acc ^ (acc >> hkit_pkg::SH_POST);
            if (limb == 2'd3) begin
              done  <= 1'b1;
              state <= H_IDLE;
            end else begin
              limb  <= limb + 2'd1;
              state <= H_PRE;
            end
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/hashed_key_index_table_unit.sv
// ----------------------------------------------------------------------------
// hashed_key_index_table_unit
// Store of 256-bit keys with a linear-probing slot index in RAM.
// ----------------------------------------------------------------------------
// Issue a transaction with start while busy is low; exactly one result comes
// back later as a one-cycle done strobe with rsp, and it cannot be stalled,
// so capture it on that cycle. One transaction is handled at a time. After
// reset, and for every clear transaction, the slot RAM is swept to zero one
// slot per cycle (all 2^SLOT_BITS slots, 512 by default) with busy high;
// cfg_we writes are still taken. A lookup or append first runs the key
// through the hash unit (4 limbs, bound by its single 32x32 multiplier),
// picks up the hash, then reads and checks each probed slot and, for an
// occupied slot, reads and compares its key (slot and key RAMs each have
// registered read data), then responds. A full store, or an unused opcode,
// responds without hashing or probing.
// ----------------------------------------------------------------------------
module hashed_key_index_table_unit #(
  parameter int ENTRIES   = hkit_pkg::ENTRIES_DEF,
  parameter int SLOT_BITS = hkit_pkg::SLOT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  hkit_pkg::cmd_t              cmd,
  output logic                        done,
  output hkit_pkg::rsp_t              rsp,
  input  logic                        cfg_we,
  input  logic [hkit_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);   // slot value = index + 1
  localparam int SLOTS = 1 << SLOT_BITS;
  localparam logic [4:0]       SB5      = 5'(SLOT_BITS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CLEAR    = 7'b0000010,
    S_HASH     = 7'b0000100,
    S_SLOT_RD  = 7'b0001000,
    S_SLOT_CHK = 7'b0010000,
    S_KEY_CHK  = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t                     state;
  hkit_pkg::cmd_t             cmd_q;
  logic [hkit_pkg::CFG_W-1:0] cfg_bits;
  logic [CNT_W-1:0]           count;
  logic [SLOT_BITS-1:0]       slot;
  logic [SLOT_BITS-1:0]       probe_n;
  logic [SLOT_BITS-1:0]       clr_ptr;
  logic                       clr_reply;
  logic [IDX_W-1:0]           hit_idx;
  logic                       hit;
  logic                       empty;
  logic                       store_full;

  // active mask from clamped register
  logic [4:0]           bits_act;
  logic [SLOT_BITS:0]   one_sh;
  logic [SLOT_BITS-1:0] mask;

  logic                 hash_start;
  logic                 hash_done;
  logic [63:0]          hash;

  logic                 slot_we;
  logic [SLOT_BITS-1:0] slot_waddr;
  logic [CNT_W-1:0]     slot_wdata;
  logic [CNT_W-1:0]     slot_rdata;
  logic                 key_we;
  logic [hkit_pkg::KEY_W-1:0] key_vec;
  logic [hkit_pkg::KEY_W-1:0] key_rdata;
  logic [CNT_W-1:0]     entry_m1;
  logic                 append_ok;
  logic                 accept;
  logic                 at_end;

  always_comb begin
    if ({1'b0, cfg_bits} < hkit_pkg::MIN_SLOT_BITS) begin
      bits_act = hkit_pkg::MIN_SLOT_BITS;
    end else if ({1'b0, cfg_bits} > SB5) begin
      bits_act = SB5;
    end else begin
      bits_act = {1'b0, cfg_bits};
    end
    one_sh = (SLOT_BITS + 1)'(1) << bits_act;
    mask   = SLOT_BITS'(one_sh - 1'b1);
  end

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign hash_start = accept && ((cmd.operation == hkit_pkg::OP_LOOKUP) ||
                      ((cmd.operation == hkit_pkg::OP_APPEND) && (count < CNT_FULL)));
  assign key_vec    = {cmd_q.key_limb3, cmd_q.key_limb2, cmd_q.key_limb1, cmd_q.key_limb0};
  assign entry_m1   = slot_rdata - 1'b1;
  assign append_ok  = (cmd_q.operation == hkit_pkg::OP_APPEND) && !store_full && (hit || empty);
  assign at_end     = (probe_n == mask);

  // RAM port control: clear sweep and append share the slot write port
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot;
    slot_wdata = count + 1'b1;
    key_we     = 1'b0;
    if (state == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_ptr;
      slot_wdata = '0;
    end else if (state == S_FINISH && append_ok) begin
      slot_we = 1'b1;
      key_we  = 1'b1;
    end
  end

  // hash works from the captured key, valid from the cycle after accept
  hkit_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (cmd_q),
    .done  (hash_done),
    .hash  (hash)
  );

  hkit_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot),
    .rdata (slot_rdata)
  );

  hkit_ram #(.WIDTH(hkit_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (key_vec),
    .raddr (entry_m1[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      clr_reply <= 1'b0;
      count     <= '0;
      cfg_bits  <= hkit_pkg::CFG_RESET;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        cfg_bits <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q      <= cmd;
            hit        <= 1'b0;
            empty      <= 1'b0;
            store_full <= (cmd.operation == hkit_pkg::OP_APPEND) && (count >= CNT_FULL);
            if (hash_start) begin
              state <= S_HASH;
            end else if (cmd.operation == hkit_pkg::OP_CLEAR) begin
              clr_ptr   <= '0;
              clr_reply <= 1'b1;
              count     <= '0;
              state     <= S_CLEAR;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (&clr_ptr) begin
            state <= clr_reply ? S_FINISH : S_IDLE;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot    <= hash[SLOT_BITS-1:0] & mask;
            probe_n <= '0;
            state   <= S_SLOT_RD;
          end
        end
        S_SLOT_RD: state <= S_SLOT_CHK;
        S_SLOT_CHK: begin
          hit_idx <= entry_m1[IDX_W-1:0];
          if (slot_rdata == '0) begin
            empty <= 1'b1;
            state <= S_FINISH;
          end else if (entry_m1 < count) begin
            state <= S_KEY_CHK;
          end else if (at_end) begin
            state <= S_FINISH;
          end else begin
            probe_n <= probe_n + 1'b1;
            slot    <= (slot + 1'b1) & mask;
            state   <= S_SLOT_RD;
          end
        end
        S_KEY_CHK: begin
          if (key_rdata == key_vec) begin
            hit   <= 1'b1;
            state <= S_FINISH;
          end else if (at_end) begin
            state <= S_FINISH;
          end else begin
            probe_n <= probe_n + 1'b1;
            slot    <= (slot + 1'b1) & mask;
            state   <= S_SLOT_RD;
          end
        end
        S_FINISH: begin
          done             <= 1'b1;
          clr_reply        <= 1'b0;
          rsp.found        <= 1'b0;
          rsp.result_index <= '0;
          rsp.status       <= hkit_pkg::ST_OK;
          if (cmd_q.operation == hkit_pkg::OP_LOOKUP) begin
            if (hit) begin
              rsp.found        <= 1'b1;
              rsp.result_index <= hkit_pkg::RIDX_W'(hit_idx);
            end
          end else if (cmd_q.operation == hkit_pkg::OP_APPEND) begin
            if (store_full) begin
              rsp.status <= hkit_pkg::ST_STORE_FULL;
            end else if (append_ok) begin
              rsp.found        <= 1'b1;
              rsp.result_index <= hkit_pkg::RIDX_W'(count);
              count            <= count + 1'b1;
            end else begin
              rsp.status <= hkit_pkg::ST_INDEX_FULL;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/hkit_checker.sv
// ----------------------------------------------------------------------------
// hkit_checker
// Port-level checks on the hashed key index table, bound to the top level.
// ----------------------------------------------------------------------------
module hkit_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input hkit_pkg::rsp_t rsp
);

  // an accepted transaction raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // no two result strobes back to back
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == hkit_pkg::ST_OK || rsp.status == hkit_pkg::ST_STORE_FULL ||
              rsp.status == hkit_pkg::ST_INDEX_FULL))
    else $error("unknown status code");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != hkit_pkg::ST_OK |-> !rsp.found && rsp.result_index == '0)
    else $error("failed transaction reported a hit or index");

endmodule

bind hashed_key_index_table_unit hkit_checker u_hkit_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
